>>> src/mase_pkg.sv
// Shared constants, request and operation codes, and the ALU control struct
// of the matrix add/subtract/multiply engine. No dependencies.
package mase_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int DIM_W      = 4;
  localparam int REQ_W      = 2;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Stream payload widths: fields packed from bit 0, padded to whole bytes.
  localparam int PAY_W      = ELEM_WIDTH + 2 * IDX_W;
  localparam int TDATA_W    = ((PAY_W + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - PAY_W;

  // Request kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // Operation codes, as held in the op_mode register
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS  = 3'd4;

  // One term handed to the shared arithmetic unit
  typedef struct packed {
    logic            vld;
    logic            first;  // clear the accumulator with this term
    logic            last;   // final term of one result element
    logic [OP_W-1:0] op;
  } alu_ctl_t;

endpackage

>>> src/mase_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module mase_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mase_alu.sv
// Shared arithmetic unit: one add, subtract or multiply per cycle, registered,
// followed by a wrapping accumulator. Depends on mase_pkg.
module mase_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mase_pkg::alu_ctl_t                ctl_i,
  input  logic [mase_pkg::ELEM_WIDTH-1:0]   a_i,
  input  logic [mase_pkg::ELEM_WIDTH-1:0]   b_i,
  output logic                              done_o,
  output logic [mase_pkg::ELEM_WIDTH-1:0]   acc_o
);
  import mase_pkg::*;

  alu_ctl_t              ctl_q;
  logic [ELEM_WIDTH-1:0] term_d, term_q;
  logic [ELEM_WIDTH-1:0] acc_d, acc_q;
  logic                  done_q;

  // Low bits only: every operation wraps modulo 2^ELEM_WIDTH
  always_comb begin
    case (ctl_i.op)
      OP_ADD:  term_d = a_i + b_i;
      OP_SUB:  term_d = a_i - b_i;
      OP_MUL:  term_d = a_i * b_i;
      default: term_d = '0;
    endcase
  end

  assign acc_d = (ctl_q.first ? '0 : acc_q) + term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_q <= ctl_q.vld & ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      term_q <= term_d;
    end
    if (ctl_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

>>> src/matrix_add_sub_mul_engine.sv
// Top level of the integer matrix add/subtract/multiply engine: sequencer,
// operand stores and result register. Depends on mase_pkg, mase_ram, mase_alu.
//
// Usage:
//   Slave stream (s_axis_*) carries requests: tuser selects load A, load B or
//   compute; tdata holds row, column and the signed element for loads.
//   A load gives no result. A compute streams the result
//   matrix on the master stream (m_axis_*) in row-major order, tlast on the
//   final element; on a dimension or mode mismatch one error item is sent
//   instead (tuser = 1, tlast = 1, data zero).
//   Configuration writes (cfg_*) are always taken; write them only while idle.
// Flow:
//   One shared unit computes every element: an element needs K terms,
//   K = a_cols for a product and 1 for a sum or difference, which pass
//   through the read/operate/accumulate pipeline of the unit. s_axis_tready is
//   high only while no compute is running.
// Reset: both stores read as zero (per-entry valid bits), op_mode is add and
//   all dimensions are 8. If the receiver stalls, the output register holds its
//   item until taken; the sequencer stalls with the result in the accumulator.
module matrix_add_sub_mul_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: row_index[2:0], col_index[5:3], element_value[37:6], zero pad
  input  logic [mase_pkg::TDATA_W-1:0]      s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [mase_pkg::REQ_W-1:0]        s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: result_value[31:0], result_row[34:32], result_col[37:35], zero pad
  output logic [mase_pkg::TDATA_W-1:0]      m_axis_tdata,
  // tuser: dim_error[0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mase_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [mase_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mase_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_WAIT = 5'b00100,
    S_EMIT = 5'b01000,
    S_ERR  = 5'b10000
  } state_e;

  state_e state_d, state_q;

  logic [OP_W-1:0]  op_mode_q;
  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  logic [IDX_W-1:0] i_d, i_q, j_d, j_q, k_d, k_q;
  logic [DEPTH-1:0] a_vld_q, b_vld_q;

  // Input unpack
  logic [IDX_W-1:0]      in_row, in_col;
  logic [ELEM_WIDTH-1:0] in_val;
  logic                  in_acc;
  logic [ADDR_W-1:0]     waddr;
  logic                  we_a, we_b;

  assign in_row = s_axis_tdata[IDX_W-1:0];
  assign in_col = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_val = s_axis_tdata[2*IDX_W +: ELEM_WIDTH];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign waddr  = {in_row, in_col};
  assign we_a   = in_acc && (s_axis_tuser == REQ_LOAD_A);
  assign we_b   = in_acc && (s_axis_tuser == REQ_LOAD_B);

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= OP_ADD;
      a_rows_q  <= DIM_W'(MAX_DIM);
      a_cols_q  <= DIM_W'(MAX_DIM);
      b_rows_q  <= DIM_W'(MAX_DIM);
      b_cols_q  <= DIM_W'(MAX_DIM);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_OP_MODE: op_mode_q <= cfg_data_i[OP_W-1:0];
        REG_A_ROWS:  a_rows_q  <= cfg_data_i;
        REG_A_COLS:  a_cols_q  <= cfg_data_i;
        REG_B_ROWS:  b_rows_q  <= cfg_data_i;
        REG_B_COLS:  b_cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Dimension check and loop bounds
  logic             is_mul, is_addsub, dims_in_range, dims_ok;
  logic [DIM_W-1:0] n_cols, n_k;
  logic             last_i, last_j, last_k;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (d <= DIM_W'(MAX_DIM));
  endfunction

  assign is_mul    = (op_mode_q == OP_MUL);
  assign is_addsub = (op_mode_q == OP_ADD) || (op_mode_q == OP_SUB);
  assign dims_in_range = dim_ok(a_rows_q) && dim_ok(a_cols_q) &&
                         dim_ok(b_rows_q) && dim_ok(b_cols_q);
  assign dims_ok = dims_in_range &&
                   ((is_addsub && (a_rows_q == b_rows_q) && (a_cols_q == b_cols_q)) ||
                    (is_mul && (a_cols_q == b_rows_q)));

  assign n_cols = is_mul ? b_cols_q : a_cols_q;
  assign n_k    = is_mul ? a_cols_q : DIM_W'(1);
  assign last_i = ((DIM_W'(i_q) + DIM_W'(1)) == a_rows_q);
  assign last_j = ((DIM_W'(j_q) + DIM_W'(1)) == n_cols);
  assign last_k = ((DIM_W'(k_q) + DIM_W'(1)) == n_k);

  // Operand reads: A[i][k] * B[k][j] for a product, A[i][j] op B[i][j] else
  logic [ADDR_W-1:0]     rd_a, rd_b;
  logic [ELEM_WIDTH-1:0] ram_a, ram_b, opd_a, opd_b;
  logic                  a_hit_q, b_hit_q;
  alu_ctl_t              iss_ctl, rd_ctl_q;

  assign rd_a = {i_q, is_mul ? k_q : j_q};
  assign rd_b = is_mul ? {k_q, j_q} : {i_q, j_q};

  assign iss_ctl = '{vld:   (state_q == S_CALC),
                     first: (k_q == '0),
                     last:  last_k,
                     op:    op_mode_q};

  mase_ram #(
    .Width(ELEM_WIDTH),
    .Depth(DEPTH)
  ) u_store_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr),
    .wdata_i(in_val),
    .raddr_i(rd_a),
    .rdata_o(ram_a)
  );

  mase_ram #(
    .Width(ELEM_WIDTH),
    .Depth(DEPTH)
  ) u_store_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr),
    .wdata_i(in_val),
    .raddr_i(rd_b),
    .rdata_o(ram_b)
  );

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= '0;
      b_vld_q  <= '0;
      a_hit_q  <= 1'b0;
      b_hit_q  <= 1'b0;
      rd_ctl_q <= '0;
    end else begin
      if (we_a) begin
        a_vld_q[waddr] <= 1'b1;
      end
      if (we_b) begin
        b_vld_q[waddr] <= 1'b1;
      end
      a_hit_q  <= a_vld_q[rd_a];
      b_hit_q  <= b_vld_q[rd_b];
      rd_ctl_q <= iss_ctl;
    end
  end

  assign opd_a = a_hit_q ? ram_a : '0;
  assign opd_b = b_hit_q ? ram_b : '0;

  logic                  alu_done;
  logic [ELEM_WIDTH-1:0] alu_acc;

  mase_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (rd_ctl_q),
    .a_i   (opd_a),
    .b_i   (opd_b),
    .done_o(alu_done),
    .acc_o (alu_acc)
  );

  // Sequencer
  logic out_free, load_res, load_err;

  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign load_res = (state_q == S_EMIT) && out_free;
  assign load_err = (state_q == S_ERR) && out_free;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == REQ_COMPUTE)) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = dims_ok ? S_CALC : S_ERR;
        end
      end
      S_CALC: begin
        // issue one term per cycle, stop after the last one
        if (last_k) begin
          k_d     = '0;
          state_d = S_WAIT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (last_i && last_j) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_CALC;
            if (last_j) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Output register: hold the item until the receiver takes it
  logic                  out_vld_q;
  logic [ELEM_WIDTH-1:0] out_value_q;
  logic [IDX_W-1:0]      out_row_q, out_col_q;
  logic                  out_last_q, out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_res || load_err) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_value_q <= alu_acc;
      out_row_q   <= i_q;
      out_col_q   <= j_q;
      out_last_q  <= last_i & last_j;
      out_err_q   <= 1'b0;
    end else if (load_err) begin
      out_value_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b1;
      out_err_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_col_q, out_row_q, out_value_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

endmodule
